### hdl/gspc_pkg.sv
package gspc_pkg;

  localparam int ADC_BITS            = 12;
  localparam int TABLE_FRACTION_BITS = 12;
  localparam int SPR_DEFAULT         = 10;
  localparam int EXP_FRAC            = 12;   // curve exponent is Q3.12
  localparam int FULL_CV             = 330;
  localparam int CV_W                = 9;
  localparam int CAL_W               = 16;
  localparam int EXPN_W              = 15;
  localparam int PPM_W               = 32;
  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 16;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_PPM   = 1'b0,
    REG_CURVE_EXP = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] adc_sample;
    logic                recalibrate;
  } in_item_t;

  typedef struct packed {
    logic [PPM_W-1:0] ppm_q8;
    logic [CV_W-1:0]  centivolts;
    logic             saturated;
    logic             calibrated_now;
  } out_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  // 2^(2^-k) in Q30, built by repeated truncating square roots from 2.0
  function automatic logic [30:0] exp2_factor(int k);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 31;
    for (int j = 1; j <= k; j++) begin
      v = c << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 64'd0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
    end
    return c[30:0];
  endfunction

endpackage

### hdl/gspc_mul.sv
module gspc_mul (
  input  logic              clk,
  input  gspc_pkg::mul_req_t req,
  output logic [63:0]       prod
);

  logic [63:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

  assign prod = prod_r;

endmodule

### hdl/gas_sensor_ppm_converter.sv
// A sample that does not complete a reading is added to the running sum.
// A completing sample runs the divide (reciprocal multiply), the voltage, up to
// three log2 passes (none at an end voltage) and, where the reading needs them,
// the exponent term and an exp2 pass, all on the one shared multiplier, then
// shift and output; an output stall holds the result in ST_OUT.
// Reset (sync, active low): sum/count 0, calibration pending, reference 0.
module gas_sensor_ppm_converter #(
  parameter int SAMPLES_PER_READING = gspc_pkg::SPR_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  gspc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output gspc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [gspc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gspc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gspc_pkg::*;

  localparam int TFB     = TABLE_FRACTION_BITS;
  localparam int SUM_W   = ADC_BITS + $clog2(SAMPLES_PER_READING);
  localparam int CNT_W   = $clog2(SAMPLES_PER_READING + 1);
  // floor(sum / SPR) == (sum * RECIP) >> RECIP_SH for every sum below 2^SUM_W
  localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_READING);
  localparam logic [31:0] RECIP = 32'(((64'd1 << RECIP_SH) + 64'(SAMPLES_PER_READING)
                                       - 64'd1) / 64'(SAMPLES_PER_READING));
  localparam int K_W     = $clog2(TFB + 1);
  localparam int BI_W    = $clog2(TFB);
  localparam int LOGU_W  = 4 + TFB;          // msb index of a 16-bit value plus fraction
  localparam int LOG_W   = LOGU_W + 2;       // signed log ratio
  localparam int DELTA_W = LOG_W + 1;
  localparam int TQ_W    = DELTA_W + EXPN_W - EXP_FRAC + 2;
  localparam int Y_W     = TQ_W + 2;
  localparam logic signed [Y_W-1:0] Y_OFF = Y_W'(8 << TFB);
  localparam logic [EXP_FRAC-1:0] ROUND_UP = '1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_QUO, ST_CV_MUL, ST_CV, ST_LOG_INIT, ST_LOG_MUL, ST_LOG_STEP,
    ST_LOG_DONE, ST_T_MUL, ST_T, ST_EXP_MUL, ST_EXP_STEP, ST_SHIFT, ST_OUT
  } state_t;

  typedef enum logic [1:0] {LG_HI, LG_LO, LG_CAL} log_sel_t;

  state_t state_r;
  log_sel_t log_sel_r;

  // configuration
  logic [CAL_W-1:0]  cal_ppm_r;
  logic [EXPN_W-1:0] curve_exp_r;

  // accumulation
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_r;
  logic signed [LOG_W-1:0] ref_r;

  // divide by samples per reading on the shared multiplier
  logic [SUM_W-1:0]  num_r;
  logic [SUM_W-1:0]  quo_r;

  // log2 / exp2 iteration
  logic [15:0]       log_x_r;
  logic [30:0]       m_r;
  logic [LOGU_W-1:0] lg_r;
  logic [LOGU_W-1:0] l_hi_r;
  logic [K_W-1:0]    k_r;
  logic signed [DELTA_W-1:0] delta_r;
  logic signed [TQ_W-1:0]    tq_r;
  logic [TFB-1:0]    frac_r;
  logic [4:0]        ip_r;
  logic [30:0]       res_r;

  // result
  logic [PPM_W-1:0] ppm_r;
  logic [CV_W-1:0]  cv_r;
  logic             sat_r;
  logic             caln_r;
  logic             out_valid_r;
  out_item_t        out_data_r;

  mul_req_t    mreq;
  logic [63:0] prod;

  gspc_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (prod)
  );

  // exp2 factor table, one entry per fraction bit
  logic [30:0] fact [TFB];
  for (genvar g = 0; g < TFB; g++) begin : g_fact
    localparam logic [30:0] FV = exp2_factor(g + 1);
    assign fact[g] = FV;
  end

  logic             acc_last;
  logic [SUM_W-1:0] sum_add;
  logic [31:0]      cv_full;
  logic [CV_W-1:0]  cv_v;
  logic [3:0]       lg_n;
  logic [31:0]      m2;
  logic [BI_W-1:0]  bit_idx;
  logic [BI_W-1:0]  k_idx;
  logic signed [LOG_W-1:0] lr_v;
  logic [DELTA_W-1:0] d_mag;
  logic [32:0]      t_mag;
  logic [TQ_W-1:0]  tq_mag;
  logic signed [TQ_W-1:0] tq_v;
  logic signed [Y_W-1:0]  y_v;
  logic [Y_W-TFB-1:0] y_ip;
  logic [PPM_W-1:0] shifted;

  assign sum_add  = sum_r + SUM_W'(in_data.adc_sample);
  assign acc_last = (cnt_r == CNT_W'(SAMPLES_PER_READING - 1));
  assign cv_full  = (prod[31:0] + (32'd1 << (ADC_BITS - 1))) >> ADC_BITS;
  assign cv_v     = (cv_full > 32'(FULL_CV)) ? CV_W'(FULL_CV) : cv_full[CV_W-1:0];
  assign m2       = prod[61:30];
  assign bit_idx  = BI_W'(TFB - int'(k_r));
  assign k_idx    = BI_W'(k_r - K_W'(1));
  assign lr_v     = $signed({2'b00, l_hi_r}) - $signed({2'b00, lg_r});
  assign d_mag    = delta_r[DELTA_W-1] ? DELTA_W'(-delta_r) : DELTA_W'(delta_r);
  assign t_mag    = prod[32:0];
  // negative products round toward minus infinity
  assign tq_mag   = delta_r[DELTA_W-1]
                  ? TQ_W'((t_mag + 33'(ROUND_UP)) >> EXP_FRAC)
                  : TQ_W'(t_mag >> EXP_FRAC);
  assign tq_v     = delta_r[DELTA_W-1] ? -$signed(tq_mag) : $signed(tq_mag);
  assign y_v      = $signed({{(Y_W-LOGU_W){1'b0}}, lg_r})
                  + {{(Y_W-TQ_W){tq_r[TQ_W-1]}}, tq_r} + Y_OFF;
  assign y_ip     = y_v[Y_W-1:TFB];
  assign shifted  = (ip_r == 5'd31) ? {res_r, 1'b0}
                  : (ip_r == 5'd30) ? {1'b0, res_r}
                  : PPM_W'(res_r >> (5'd30 - ip_r));

  always_comb begin
    lg_n = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (log_x_r[i]) lg_n = 4'(i);
    end
  end

  always_comb begin
    mreq = '0;
    unique case (state_r)
      ST_DIV: begin
        mreq.a = 32'(num_r);
        mreq.b = RECIP;
      end
      ST_CV_MUL: begin
        mreq.a = 32'(FULL_CV);
        mreq.b = 32'(quo_r[ADC_BITS-1:0]);
      end
      ST_LOG_MUL: begin
        mreq.a = {1'b0, m_r};
        mreq.b = {1'b0, m_r};
      end
      ST_T_MUL: begin
        mreq.a = 32'(d_mag);
        mreq.b = 32'(curve_exp_r);
      end
      ST_EXP_MUL: begin
        mreq.a = {1'b0, res_r};
        mreq.b = frac_r[bit_idx] ? {1'b0, fact[k_idx]} : {1'b0, ONE_Q30};
      end
      default: mreq = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cal_ppm_r   <= CAL_W'(20);
      curve_exp_r <= EXPN_W'(8495);
      sum_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b1;
      ref_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_CAL_PPM:   cal_ppm_r   <= cfg_wdata[CAL_W-1:0];
          REG_CURVE_EXP: curve_exp_r <= cfg_wdata[EXPN_W-1:0];
          default: ;
        endcase
      end
      // ST_OUT reloads the register itself
      if (out_valid_r && out_ready && state_r != ST_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.recalibrate) pend_r <= 1'b1;
            if (acc_last) begin
              sum_r   <= '0;
              cnt_r   <= '0;
              num_r   <= sum_add;
              state_r <= ST_DIV;
            end else begin
              sum_r <= sum_add;
              cnt_r <= cnt_r + CNT_W'(1);
            end
          end
        end
        ST_DIV: state_r <= ST_QUO;
        ST_QUO: begin
          quo_r   <= SUM_W'(prod >> RECIP_SH);
          state_r <= ST_CV_MUL;
        end
        ST_CV_MUL: state_r <= ST_CV;
        ST_CV: begin
          cv_r   <= cv_v;
          sat_r  <= 1'b0;
          caln_r <= 1'b0;
          if (cv_v == '0) begin
            ppm_r   <= '0;
            state_r <= ST_OUT;
          end else if (cv_v == CV_W'(FULL_CV)) begin
            ppm_r   <= '1;
            sat_r   <= 1'b1;
            state_r <= ST_OUT;
          end else begin
            log_x_r   <= 16'(CV_W'(FULL_CV) - cv_v);
            log_sel_r <= LG_HI;
            state_r   <= ST_LOG_INIT;
          end
        end
        ST_LOG_INIT: begin
          m_r     <= 31'({15'd0, log_x_r} << (5'd30 - 5'(lg_n)));
          lg_r    <= LOGU_W'(lg_n) << TFB;
          k_r     <= K_W'(1);
          state_r <= ST_LOG_MUL;
        end
        ST_LOG_MUL: state_r <= ST_LOG_STEP;
        ST_LOG_STEP: begin
          if (m2[31]) begin
            m_r  <= m2[31:1];
            lg_r <= lg_r | (LOGU_W'(1) << bit_idx);
          end else begin
            m_r <= m2[30:0];
          end
          if (k_r == K_W'(TFB)) begin
            state_r <= ST_LOG_DONE;
          end else begin
            k_r     <= k_r + K_W'(1);
            state_r <= ST_LOG_MUL;
          end
        end
        ST_LOG_DONE: begin
          unique case (log_sel_r)
            LG_HI: begin
              l_hi_r    <= lg_r;
              log_x_r   <= 16'(cv_r);
              log_sel_r <= LG_LO;
              state_r   <= ST_LOG_INIT;
            end
            LG_LO: begin
              if (pend_r) begin
                ref_r   <= lr_v;
                pend_r  <= 1'b0;
                caln_r  <= 1'b1;
                ppm_r   <= PPM_W'(cal_ppm_r) << 8;
                state_r <= ST_OUT;
              end else if (cal_ppm_r == '0) begin
                ppm_r   <= '0;
                state_r <= ST_OUT;
              end else begin
                delta_r <= DELTA_W'(ref_r) - DELTA_W'(lr_v);
                state_r <= ST_T_MUL;
              end
            end
            LG_CAL: begin
              if (y_v < 0) begin
                ppm_r   <= '0;
                state_r <= ST_OUT;
              end else if (y_ip >= (Y_W-TFB)'(32)) begin
                ppm_r   <= '1;
                sat_r   <= 1'b1;
                state_r <= ST_OUT;
              end else begin
                frac_r  <= y_v[TFB-1:0];
                ip_r    <= y_ip[4:0];
                res_r   <= ONE_Q30;
                k_r     <= K_W'(1);
                state_r <= ST_EXP_MUL;
              end
            end
            default: state_r <= ST_IDLE;
          endcase
        end
        ST_T_MUL: state_r <= ST_T;
        ST_T: begin
          if (tq_v == '0) begin
            ppm_r   <= PPM_W'(cal_ppm_r) << 8;
            state_r <= ST_OUT;
          end else begin
            tq_r      <= tq_v;
            log_x_r   <= cal_ppm_r;
            log_sel_r <= LG_CAL;
            state_r   <= ST_LOG_INIT;
          end
        end
        ST_EXP_MUL: state_r <= ST_EXP_STEP;
        ST_EXP_STEP: begin
          res_r <= prod[60:30];
          if (k_r == K_W'(TFB)) begin
            state_r <= ST_SHIFT;
          end else begin
            k_r     <= k_r + K_W'(1);
            state_r <= ST_EXP_MUL;
          end
        end
        ST_SHIFT: begin
          ppm_r   <= shifted;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          // wait for the result register to free up
          if (!out_valid_r || out_ready) begin
            out_valid_r               <= 1'b1;
            out_data_r.ppm_q8         <= ppm_r;
            out_data_r.centivolts     <= cv_r;
            out_data_r.saturated      <= sat_r;
            out_data_r.calibrated_now <= caln_r;
            state_r                   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.saturated || out_data.ppm_q8 == '1))
    else $error("saturated result not all ones");

  a_cal_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.calibrated_now) |->
      (out_data.centivolts != '0 && out_data.centivolts != CV_W'(FULL_CV)))
    else $error("reference taken at an end voltage");

  a_cv_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.centivolts <= CV_W'(FULL_CV)))
    else $error("centivolts out of range");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(SAMPLES_PER_READING))
    else $error("sample count overran");

  a_cal_clears_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOG_DONE && log_sel_r == LG_LO && pend_r) |=> !pend_r)
    else $error("pending flag not cleared on calibration");

endmodule

### bench/gas_sensor_ppm_converter_tb.sv
`timescale 1ns / 1ps

module gas_sensor_ppm_converter_tb;
  import gspc_pkg::*;

  localparam int SPR        = SPR_DEFAULT;
  localparam int IDLE_LIMIT = 5000;  // cycles without any handshake
  localparam int SETTLE     = 200;   // wait after the expected-readings queue drains
  localparam int HOLD_LEN   = 400;   // long receiver back-pressure stretch

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  gas_sensor_ppm_converter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Converter model: own copy of registers and reading state
  // ---------------------------------------------------------------------------
  logic [CAL_W-1:0]  cal_ppm;
  logic [EXPN_W-1:0] curve_exp;
  int unsigned       acc_sum;
  int unsigned       acc_cnt;
  bit                cal_pending;
  longint            ref_lr;      // log2(RS0/RL), Q.12

  out_item_t readings_due[$];     // expected readings, oldest first
  int        fail_cnt = 0;
  int        idle_cycles = 0;
  bit        hold_req = 1'b0;
  int        burst_left = 0;

  // log2 of x (>=1), Q.12, truncated, via repeated squaring of a Q30 mantissa
  function automatic longint log2_q12(int unsigned x);
    int unsigned       n;
    longint unsigned   m;
    longint unsigned   r;
    n = 0;
    while ((x >> n) > 1) n++;
    m = longint'(x) << (30 - n);
    r = longint'(n) << TABLE_FRACTION_BITS;
    for (int k = 1; k <= TABLE_FRACTION_BITS; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r = r | (64'd1 << (TABLE_FRACTION_BITS - k));
      end
    end
    return longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(f/4096) in Q30
  function automatic longint unsigned pow2_frac_q30(longint unsigned f);
    longint unsigned acc;
    longint unsigned fac;
    acc = 64'd1 << 30;
    fac = 64'd2 << 30;
    for (int k = 1; k <= TABLE_FRACTION_BITS; k++) begin
      fac = int_sqrt(fac << 30);
      if (((f >> (TABLE_FRACTION_BITS - k)) & 1) != 0) acc = (acc * fac) >> 30;
    end
    return acc;
  endfunction

  function automatic longint sensor_log_ratio(int unsigned cv);
    return log2_q12(FULL_CV - cv) - log2_q12(cv);
  endfunction

  // Advances the model by one accepted sample; returns 1 when a reading completes.
  function automatic bit model_sample(in_item_t it, output out_item_t res);
    int unsigned     avg;
    int unsigned     cv;
    longint          delta;
    longint          t;
    longint          tq;
    longint          y;
    longint unsigned ip;
    longint unsigned mant;
    res = '0;
    if (it.recalibrate) cal_pending = 1'b1;
    acc_sum += it.adc_sample;
    acc_cnt++;
    if (acc_cnt < SPR) return 1'b0;
    avg = acc_sum / SPR;
    acc_sum = 0;
    acc_cnt = 0;
    cv = (FULL_CV * avg + (1 << (ADC_BITS - 1))) >> ADC_BITS;
    if (cv > FULL_CV) cv = FULL_CV;
    res.centivolts = cv[CV_W-1:0];
    if (cv == 0) begin
      res.ppm_q8 = '0;
    end else if (cv == FULL_CV) begin
      res.ppm_q8 = '1;
      res.saturated = 1'b1;
    end else if (cal_pending) begin
      ref_lr = sensor_log_ratio(cv);
      cal_pending = 1'b0;
      res.calibrated_now = 1'b1;
      res.ppm_q8 = 32'({cal_ppm, 8'h00});
    end else if (cal_ppm != 0) begin
      delta = ref_lr - sensor_log_ratio(cv);
      t = delta * longint'(curve_exp);
      tq = t >>> EXP_FRAC;  // floor
      if (tq == 0) begin
        res.ppm_q8 = 32'({cal_ppm, 8'h00});
      end else begin
        y = log2_q12(cal_ppm) + tq + (longint'(8) << TABLE_FRACTION_BITS);
        if (y >= 0) begin
          ip = longint'(y) >> TABLE_FRACTION_BITS;
          mant = pow2_frac_q30(longint'(y) & ((64'd1 << TABLE_FRACTION_BITS) - 1));
          if (ip >= 32) begin
            res.ppm_q8 = '1;
            res.saturated = 1'b1;
          end else if (ip >= 30) begin
            res.ppm_q8 = 32'(mant << (ip - 30));
          end else begin
            res.ppm_q8 = 32'(mant >> (30 - ip));
          end
        end
      end
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps; changes at falling edge
  // ---------------------------------------------------------------------------
  task automatic send_sample(in_item_t it, bit pinned, out_item_t pinned_res);
    out_item_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 3) != 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    if (model_sample(it, res)) readings_due.push_back(pinned ? pinned_res : res);
  endtask

  // One reading of SPR samples alternating between a and b; recal on one sample
  task automatic send_reading(logic [ADC_BITS-1:0] a, logic [ADC_BITS-1:0] b,
                              bit recal, bit pinned, out_item_t pinned_res);
    in_item_t it;
    for (int i = 0; i < SPR; i++) begin
      it.adc_sample  = (i % 2 == 0) ? a : b;
      it.recalibrate = recal && (i == SPR / 2);
      send_sample(it, pinned, pinned_res);
    end
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait (readings_due.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAL_PPM) cal_ppm = val;
    else curve_exp = val[EXPN_W-1:0];
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        case ($urandom_range(0, 5))
          0:       out_ready <= 1'b0;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker and watchdog, sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected reading ppm=%h cv=%0d", $time,
                   out_data.ppm_q8, out_data.centivolts);
          fail_cnt++;
        end else begin
          out_item_t e;
          e = readings_due.pop_front();
          if (out_data.ppm_q8 !== e.ppm_q8) begin
            $display("%0t: ppm_q8 expected %h got %h", $time, e.ppm_q8, out_data.ppm_q8);
            fail_cnt++;
          end
          if (out_data.centivolts !== e.centivolts) begin
            $display("%0t: centivolts expected %0d got %0d", $time,
                     e.centivolts, out_data.centivolts);
            fail_cnt++;
          end
          if (out_data.saturated !== e.saturated) begin
            $display("%0t: saturated expected %b got %b", $time,
                     e.saturated, out_data.saturated);
            fail_cnt++;
          end
          if (out_data.calibrated_now !== e.calibrated_now) begin
            $display("%0t: calibrated_now expected %b got %b", $time,
                     e.calibrated_now, out_data.calibrated_now);
            fail_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed readings: exact results typed in where obvious
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [ADC_BITS-1:0] a;
    logic [ADC_BITS-1:0] b;
    bit                  recal;
    bit                  pinned;
    out_item_t           res;
  } reading_row_t;

  localparam int N_ROWS = 11;
  reading_row_t rows [N_ROWS] = '{
    '{12'hFFF, 12'hFFF, 1'b0, 1'b1, '{32'hFFFF_FFFF, 9'd330, 1'b1, 1'b0}}, // full: sat
    '{12'h000, 12'h000, 1'b0, 1'b1, '{32'h0, 9'd0, 1'b0, 1'b0}},           // zero volts
    '{12'd1,   12'd0,   1'b0, 1'b1, '{32'h0, 9'd0, 1'b0, 1'b0}},           // rounds to 0
    '{12'd2048, 12'd2048, 1'b0, 1'b1, '{32'd5120, 9'd165, 1'b0, 1'b1}},    // first ref
    '{12'd2048, 12'd2048, 1'b0, 1'b1, '{32'd5120, 9'd165, 1'b0, 1'b0}},    // same ratio
    '{12'd13,  12'd14,  1'b0, 1'b0, '0},                                    // cv 1
    '{12'd4089, 12'd4088, 1'b0, 1'b0, '0},                                  // cv 329
    '{12'hAAA, 12'h555, 1'b0, 1'b0, '0},                                    // bit toggles
    '{12'hFFF, 12'hFFF, 1'b1, 1'b1, '{32'hFFFF_FFFF, 9'd330, 1'b1, 1'b0}}, // deferred cal
    '{12'd3001, 12'd3000, 1'b0, 1'b0, '0},                                  // cal lands here
    '{12'd100, 12'd101, 1'b1, 1'b0, '0}                                     // recal low end
  };

  // register settings per phase, extremes included
  localparam int N_PHASES = 6;
  logic [CFG_DATA_W-1:0] cal_set [N_PHASES] = '{16'd20, 16'd1, 16'd65535, 16'd0,
                                                16'd1000, 16'd400};
  logic [CFG_DATA_W-1:0] exp_set [N_PHASES] = '{16'd8495, 16'd0, 16'd32767, 16'd8495,
                                                16'd20000, 16'd4096};

  initial begin
    out_item_t dummy;
    in_item_t  it;
    int        base;
    int        v;
    int        n_noise;
    dummy = '0;
    cal_ppm = 16'd20;
    curve_exp = 15'd8495;
    acc_sum = 0;
    acc_cnt = 0;
    cal_pending = 1'b1;
    ref_lr = 0;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_reading(rows[i].a, rows[i].b, rows[i].recal,
                                   rows[i].pinned, rows[i].res);
    drain_and_settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(REG_CAL_PPM, cal_set[p]);
      write_reg(REG_CURVE_EXP, exp_set[p]);
      if (p == 1) hold_req = 1'b1;  // back-pressure: block fills, input stalls
      for (int r = 0; r < 27; r++) begin
        if ($urandom_range(0, 4) != 0) begin
          // well-formed reading: a level with small noise; ends get extra weight
          case ($urandom_range(0, 9))
            0:       base = $urandom_range(0, 20);
            1:       base = $urandom_range(4075, 4095);
            default: base = $urandom_range(0, 4095);
          endcase
          for (int i = 0; i < SPR; i++) begin
            v = base + int'($urandom_range(0, 16)) - 8;
            if (v < 0) v = 0;
            if (v > 4095) v = 4095;
            it.adc_sample  = v[ADC_BITS-1:0];
            it.recalibrate = ($urandom_range(0, 39) == 0);
            send_sample(it, 1'b0, dummy);
          end
        end else begin
          // noise: raw random samples, random count to shift reading boundaries
          n_noise = $urandom_range(1, 13);
          for (int i = 0; i < n_noise; i++) begin
            it.adc_sample  = $urandom_range(0, 4095);
            it.recalibrate = ($urandom_range(0, 9) == 0);
            send_sample(it, 1'b0, dummy);
          end
        end
      end
      drain_and_settle();
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
